[hw/rtl/qtsba_pkg.sv]
// shared constants and types for the quadtree square block allocator
`timescale 1ns / 1ps
`default_nettype none
package qtsba_pkg;
   localparam int TREE_LEVELS_DEF = 6;
   localparam int NODE_COUNT_DEF  = 1365;
   localparam int AREA_W          = 25;
   localparam int SIDE_W          = 13;
   localparam int POS_W           = 12;
   localparam logic [SIDE_W-1:0] SIDE_LIMIT   = 13'd4096;
   localparam logic [POS_W-1:0]  BOX_MIN_INIT = 12'd4095;
   localparam logic [SIDE_W-1:0] ROOT_RESET   = 13'd1024;
   localparam logic [SIDE_W-1:0] MIN_RESET    = 13'd32;
   localparam logic CSR_ROOT_SIDE = 1'b0;
   localparam logic CSR_MIN_SIDE  = 1'b1;
   localparam logic MODE_ALLOC = 1'b0;
   localparam logic MODE_CLEAR = 1'b1;

   typedef struct packed {
      logic              granted;
      logic [POS_W-1:0]  block_x;
      logic [POS_W-1:0]  block_y;
      logic [SIDE_W-1:0] block_side;
      logic [POS_W-1:0]  bound_left;
      logic [POS_W-1:0]  bound_top;
      logic [SIDE_W-1:0] bound_right;
      logic [SIDE_W-1:0] bound_bottom;
   } rsp_type;
endpackage
`default_nettype wire

[hw/rtl/quadtree_square_block_allocator.sv]
// top level: quadtree square block allocator
// allocate reads the root, descends reading up to four children per level, reads the
//   chosen node, then updates each ancestor; a root too small for the request answers without descending
// clear sweeps the free-area ram one node a cycle, then answers;
//   register write and reset also start a sweep, during which no request is taken
// one request in flight at a time; reset: synchronous active high, then a rebuild sweep
`timescale 1ns / 1ps
`default_nettype none
module quadtree_square_block_allocator
   import qtsba_pkg::*;
#(
   parameter int TREE_LEVELS = TREE_LEVELS_DEF,
   parameter int NODE_COUNT  = NODE_COUNT_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire logic              req_mode,
   input  wire logic [SIDE_W-1:0] req_request_side,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output logic                   rsp_granted,
   output logic [POS_W-1:0]       rsp_block_x,
   output logic [POS_W-1:0]       rsp_block_y,
   output logic [SIDE_W-1:0]      rsp_block_side,
   output logic [POS_W-1:0]       rsp_bound_left,
   output logic [POS_W-1:0]       rsp_bound_top,
   output logic [SIDE_W-1:0]      rsp_bound_right,
   output logic [SIDE_W-1:0]      rsp_bound_bottom,
   input  wire logic              csr_valid,
   output logic                   csr_ready,
   input  wire logic              csr_index,
   input  wire logic [SIDE_W-1:0] csr_data
);
   localparam int AW = $clog2(NODE_COUNT);
   localparam int LW = $clog2(TREE_LEVELS + 1);

   // controller states
   localparam logic [3:0] S_SWEEP = 4'd0, S_IDLE = 4'd1, S_ROOT = 4'd2,
      S_RWAIT = 4'd3, S_CHILD = 4'd4, S_CWAIT = 4'd5, S_CCHK = 4'd6,
      S_NODE = 4'd7, S_NWAIT = 4'd8, S_ANC = 4'd9, S_AWAIT = 4'd10,
      S_AWR = 4'd11, S_DONE = 4'd12, S_OUT = 4'd13;

   logic [3:0] state_ff, state_in;
   logic [SIDE_W-1:0] root_ff, root_in, min_ff, min_in;
   logic [AW-1:0] sw_idx_ff, sw_idx_in;
   logic [LW-1:0] sw_lvl_ff, sw_lvl_in;
   logic [AW:0]   sw_end_ff, sw_end_in;
   logic [SIDE_W-1:0] sw_side_ff, sw_side_in;
   logic clr_rsp_ff, clr_rsp_in;
   logic [2*SIDE_W-1:0] area_ff, area_in;
   logic [AW-1:0] node_ff, node_in;
   logic [LW-1:0] lvl_ff, lvl_in, anc_ff, anc_in;
   logic [SIDE_W-1:0] side_ff, side_in;
   logic [POS_W:0] x_ff, x_in, y_ff, y_in;
   logic [2:0] c_ff, c_in;
   logic [AW-1:0] path_ff [TREE_LEVELS], path_in [TREE_LEVELS];
   logic [AREA_W-1:0] taken_ff, taken_in;
   logic [POS_W-1:0] bl_ff, bl_in, bt_ff, bt_in;
   logic [SIDE_W-1:0] br_ff, br_in, bb_ff, bb_in;
   logic rv_ff, rv_in;
   rsp_type rsp_ff, rsp_in;

   logic ram_we;
   logic [AW-1:0] ram_addr;
   logic [AREA_W-1:0] ram_wd, ram_rd;

   qtsba_ram #(.WIDTH(AREA_W), .DEPTH(NODE_COUNT)) u_area (
      .clock(clock), .wr_en(ram_we), .addr(ram_addr), .wr_data(ram_wd), .rd_data(ram_rd)
   );

   logic [SIDE_W-1:0] eff_root;
   assign eff_root = (root_ff > SIDE_LIMIT) ? SIDE_LIMIT : root_ff;

   logic [AW+2:0] child_idx;
   assign child_idx = {node_ff, 2'b00} + (AW+3)'(c_ff) + (AW+3)'(1);
   logic [SIDE_W-1:0] half;
   assign half = side_ff >> 1;
   logic [2*SIDE_W-1:0] side_sq;
   assign side_sq = side_ff * side_ff;
   logic [2*SIDE_W-1:0] sw_sq;
   assign sw_sq = sw_side_ff * sw_side_ff;

   assign req_stall = (state_ff != S_IDLE) || csr_valid;
   assign csr_ready = (state_ff == S_IDLE) || (state_ff == S_SWEEP);

   always_comb begin
      state_in = state_ff; root_in = root_ff; min_in = min_ff;
      sw_idx_in = sw_idx_ff; sw_lvl_in = sw_lvl_ff; sw_end_in = sw_end_ff;
      sw_side_in = sw_side_ff; clr_rsp_in = clr_rsp_ff; area_in = area_ff;
      node_in = node_ff; lvl_in = lvl_ff; anc_in = anc_ff; side_in = side_ff;
      x_in = x_ff; y_in = y_ff; c_in = c_ff; path_in = path_ff;
      taken_in = taken_ff; bl_in = bl_ff; bt_in = bt_ff; br_in = br_ff; bb_in = bb_ff;
      rv_in = rv_ff; rsp_in = rsp_ff;
      ram_we = 1'b0; ram_addr = node_ff; ram_wd = ram_rd;
      if (rv_ff && !rsp_stall) rv_in = 1'b0;
      unique case (state_ff)
         S_SWEEP: begin
            // rebuild one node a cycle, side halves at each level boundary
            ram_we = 1'b1; ram_addr = sw_idx_ff; ram_wd = AREA_W'(sw_sq);
            if ((AW+1)'(sw_idx_ff) + (AW+1)'(1) >= (AW+1)'(NODE_COUNT)) begin
               state_in = clr_rsp_ff ? S_OUT : S_IDLE;
            end else begin
               sw_idx_in = sw_idx_ff + AW'(1);
               if ((AW+1)'(sw_idx_ff) + (AW+1)'(1) == sw_end_ff) begin
                  sw_lvl_in = sw_lvl_ff + LW'(1);
                  sw_side_in = sw_side_ff >> 1;
                  sw_end_in = (sw_end_ff << 2) + (AW+1)'(1);
               end
            end
            bl_in = BOX_MIN_INIT; bt_in = BOX_MIN_INIT; br_in = '0; bb_in = '0;
         end
         S_IDLE: begin
            if (req_valid && !csr_valid) begin
               if (req_mode == MODE_CLEAR) begin
                  clr_rsp_in = 1'b1; sw_idx_in = '0; sw_lvl_in = '0;
                  sw_end_in = (AW+1)'(1); sw_side_in = eff_root; state_in = S_SWEEP;
               end else begin
                  area_in = req_request_side * req_request_side;
                  node_in = '0; lvl_in = '0; side_in = eff_root; x_in = '0; y_in = '0;
                  path_in[0] = '0; state_in = S_ROOT;
               end
            end
         end
         S_ROOT: begin ram_addr = '0; state_in = S_RWAIT; end
         S_RWAIT: begin
            if ((2*SIDE_W)'(ram_rd) < area_ff) state_in = S_DONE;
            else begin c_in = '0; state_in = S_CHILD; end
            taken_in = '0;
         end
         S_CHILD: begin
            // descend while side above minimum and below depth limit
            if (side_ff > min_ff && (LW+1)'(lvl_ff) + (LW+1)'(1) < (LW+1)'(TREE_LEVELS)
                && c_ff < 3'd4 && child_idx < (AW+3)'(NODE_COUNT)) begin
               ram_addr = child_idx[AW-1:0]; state_in = S_CWAIT;
            end else state_in = S_NODE;
         end
         S_CWAIT: begin ram_addr = child_idx[AW-1:0]; state_in = S_CCHK; end
         S_CCHK: begin
            if (ram_rd != '0 && (2*SIDE_W)'(ram_rd) >= area_ff) begin
               if (c_ff == 3'd1 || c_ff == 3'd2) y_in = y_ff + (POS_W+1)'(half);
               if (c_ff == 3'd2 || c_ff == 3'd3) x_in = x_ff + (POS_W+1)'(half);
               node_in = child_idx[AW-1:0]; side_in = half; lvl_in = lvl_ff + LW'(1);
               path_in[lvl_ff + LW'(1)] = child_idx[AW-1:0];
               c_in = '0;
            end else c_in = c_ff + 3'd1;
            state_in = S_CHILD;
         end
         S_NODE: begin ram_addr = node_ff; state_in = S_NWAIT; end
         S_NWAIT: begin
            if (ram_rd == '0 || (2*SIDE_W)'(ram_rd) != side_sq) begin
               state_in = S_DONE; taken_in = '0;
            end else begin
               taken_in = ram_rd; ram_we = 1'b1; ram_wd = '0; anc_in = '0;
               state_in = (lvl_ff == '0) ? S_DONE : S_ANC;
            end
         end
         S_ANC: begin ram_addr = path_ff[anc_ff]; state_in = S_AWAIT; end
         S_AWAIT: begin ram_addr = path_ff[anc_ff]; state_in = S_AWR; end
         S_AWR: begin
            ram_addr = path_ff[anc_ff]; ram_we = 1'b1;
            ram_wd = (ram_rd >= taken_ff) ? ram_rd - taken_ff : '0;
            anc_in = anc_ff + LW'(1);
            state_in = (anc_ff + LW'(1) == lvl_ff) ? S_DONE : S_ANC;
         end
         S_DONE: begin
            // result register must be free or emptied at this edge
            if (!rv_ff || !rsp_stall) begin
               rsp_in = '0;
               if (taken_ff != '0) begin
                  rsp_in.granted = 1'b1;
                  rsp_in.block_x = x_ff[POS_W-1:0]; rsp_in.block_y = y_ff[POS_W-1:0];
                  rsp_in.block_side = side_ff;
                  if (x_ff[POS_W-1:0] < bl_ff) bl_in = x_ff[POS_W-1:0];
                  if (y_ff[POS_W-1:0] < bt_ff) bt_in = y_ff[POS_W-1:0];
                  if (SIDE_W'(x_ff) + side_ff > br_ff) br_in = SIDE_W'(x_ff) + side_ff;
                  if (SIDE_W'(y_ff) + side_ff > bb_ff) bb_in = SIDE_W'(y_ff) + side_ff;
               end
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (!rv_ff || !rsp_stall) begin
               // a clear answers with an empty block
               if (clr_rsp_ff) rsp_in = '0;
               rsp_in.bound_left = bl_ff; rsp_in.bound_top = bt_ff;
               rsp_in.bound_right = br_ff; rsp_in.bound_bottom = bb_ff;
               rv_in = 1'b1; clr_rsp_in = 1'b0; state_in = S_IDLE;
            end
         end
         default: state_in = S_SWEEP;
      endcase
      // register write restarts the rebuild
      if (csr_valid && csr_ready) begin
         if (csr_index == CSR_ROOT_SIDE) root_in = csr_data;
         else min_in = csr_data;
         clr_rsp_in = 1'b0; sw_idx_in = '0; sw_lvl_in = '0; sw_end_in = (AW+1)'(1);
         sw_side_in = (csr_index == CSR_ROOT_SIDE)
                      ? ((csr_data > SIDE_LIMIT) ? SIDE_LIMIT : csr_data) : eff_root;
         state_in = S_SWEEP;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_SWEEP; root_ff <= ROOT_RESET; min_ff <= MIN_RESET;
         sw_idx_ff <= '0; sw_lvl_ff <= '0; sw_end_ff <= (AW+1)'(1);
         sw_side_ff <= ROOT_RESET; clr_rsp_ff <= 1'b0; rv_ff <= 1'b0;
         bl_ff <= BOX_MIN_INIT; bt_ff <= BOX_MIN_INIT; br_ff <= '0; bb_ff <= '0;
      end else begin
         state_ff <= state_in; root_ff <= root_in; min_ff <= min_in;
         sw_idx_ff <= sw_idx_in; sw_lvl_ff <= sw_lvl_in; sw_end_ff <= sw_end_in;
         sw_side_ff <= sw_side_in; clr_rsp_ff <= clr_rsp_in; rv_ff <= rv_in;
         bl_ff <= bl_in; bt_ff <= bt_in; br_ff <= br_in; bb_ff <= bb_in;
      end
      area_ff <= area_in; node_ff <= node_in; lvl_ff <= lvl_in; anc_ff <= anc_in;
      side_ff <= side_in; x_ff <= x_in; y_ff <= y_in; c_ff <= c_in;
      path_ff <= path_in; taken_ff <= taken_in; rsp_ff <= rsp_in;
   end

   assign rsp_valid = rv_ff;
   assign rsp_granted = rsp_ff.granted;
   assign rsp_block_x = rsp_ff.block_x;
   assign rsp_block_y = rsp_ff.block_y;
   assign rsp_block_side = rsp_ff.block_side;
   assign rsp_bound_left = rsp_ff.bound_left;
   assign rsp_bound_top = rsp_ff.bound_top;
   assign rsp_bound_right = rsp_ff.bound_right;
   assign rsp_bound_bottom = rsp_ff.bound_bottom;
endmodule
`default_nettype wire

[hw/rtl/qtsba_ram.sv]
// generic single port ram with registered read
`timescale 1ns / 1ps
`default_nettype none
module qtsba_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    addr,
   input  wire logic [WIDTH-1:0] wr_data,
   output logic      [WIDTH-1:0] rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   always_ff @(posedge clock) begin
      if (wr_en) mem[addr] <= wr_data;
      rd_data <= mem[addr];
   end
endmodule
`default_nettype wire

[hw/rtl/qtsba_checker.sv]
// port-level checks for the quadtree square block allocator
`timescale 1ns / 1ps
`default_nettype none
module qtsba_checker
   import qtsba_pkg::*;
(
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   input wire logic req_stall,
   input wire logic rsp_valid,
   input wire logic rsp_stall,
   input wire logic rsp_granted,
   input wire logic [SIDE_W-1:0] rsp_block_side,
   input wire logic [POS_W-1:0] rsp_block_x
);
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_granted |-> rsp_block_side == '0 && rsp_block_x == '0)
      else $error("refused request carries a block");
   a_grant_side: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_granted |-> rsp_block_side != '0)
      else $error("grant with zero side");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_granted))
      else $error("stalled response changed");
   a_one_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second request taken while busy");
endmodule

bind quadtree_square_block_allocator qtsba_checker u_qtsba_checker (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
   .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_granted(rsp_granted),
   .rsp_block_side(rsp_block_side), .rsp_block_x(rsp_block_x)
);
`default_nettype wire

[test/tb_quadtree_square_block_allocator.sv]
// self-checking testbench for the quadtree square block allocator
`timescale 1ns / 1ps
`default_nettype none
module tb_quadtree_square_block_allocator;
   import qtsba_pkg::*;

   localparam int IDLE_LIMIT = 20000;   // cycles with no handshake before giving up
   localparam int LONG_HOLD  = 400;     // long receiver hold-off, in cycles
   localparam int RAND_ITEMS = 155;     // random requests per configuration phase

   // dut ports; the inputs are driven to known values from time zero
   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   logic              req_mode = MODE_ALLOC;
   logic [SIDE_W-1:0] req_request_side = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic              rsp_granted;
   logic [POS_W-1:0]  rsp_block_x, rsp_block_y, rsp_bound_left, rsp_bound_top;
   logic [SIDE_W-1:0] rsp_block_side, rsp_bound_right, rsp_bound_bottom;
   logic              csr_valid = 1'b0;
   logic              csr_ready;
   logic              csr_index = CSR_ROOT_SIDE;
   logic [SIDE_W-1:0] csr_data = '0;

   quadtree_square_block_allocator u_top (
      .clock, .reset,
      .req_valid, .req_stall, .req_mode, .req_request_side,
      .rsp_valid, .rsp_stall, .rsp_granted, .rsp_block_x, .rsp_block_y,
      .rsp_block_side, .rsp_bound_left, .rsp_bound_top, .rsp_bound_right,
      .rsp_bound_bottom,
      .csr_valid, .csr_ready, .csr_index, .csr_data
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // shadow of the allocator: free area per node, registers and bounding box
   logic [31:0]       shadow_free [NODE_COUNT_DEF];
   logic [SIDE_W-1:0] shadow_root = ROOT_RESET;
   logic [SIDE_W-1:0] shadow_min  = MIN_RESET;
   logic [31:0]       box_lx, box_ty, box_rx, box_by;

   rsp_type placement_q [$];   // expected placements, oldest first

   int  n_err = 0, n_req = 0, n_rsp = 0, n_grant = 0, n_cfg = 0;
   bit  quiet = 1'b0;          // no idling on either side while set
   bit  long_hold = 1'b0;      // receiver holds off for a long stretch once

   function automatic int unsigned atlas_side();
      return (shadow_root > SIDE_LIMIT) ? SIDE_LIMIT : shadow_root;
   endfunction

   // every node back to its full area, box back to empty
   task automatic rebuild_tree();
      int unsigned start, count, side, k;
      start = 0;
      count = 1;
      side  = atlas_side();
      for (int lvl = 0; lvl < TREE_LEVELS_DEF && start < NODE_COUNT_DEF; lvl++) begin
         for (k = 0; k < count && start + k < NODE_COUNT_DEF; k++)
            shadow_free[start + k] = side * side;
         start += count;
         count *= 4;
         side >>= 1;
      end
      box_lx = BOX_MIN_INIT;
      box_ty = BOX_MIN_INIT;
      box_rx = 0;
      box_by = 0;
   endtask

   // walk the tree for one request and update the shadow
   task automatic place_block(input logic mode, input logic [SIDE_W-1:0] want,
                              output rsp_type res);
      longint unsigned area;
      int unsigned path [TREE_LEVELS_DEF];
      int unsigned node, lvl, x, y, side, half, ci, taken;
      bit found, ok;
      ok = 0;
      x = 0;
      y = 0;
      side = 0;
      if (mode == MODE_CLEAR) begin
         rebuild_tree();
      end else begin
         area = longint'(want) * longint'(want);
         node = 0;
         lvl  = 0;
         side = atlas_side();
         path[0] = 0;
         if (longint'(shadow_free[0]) >= area) begin
            while (side > shadow_min && lvl + 1 < TREE_LEVELS_DEF) begin
               half  = side >> 1;
               found = 0;
               for (int c = 0; c < 4 && !found; c++) begin
                  ci = 4 * node + 1 + c;
                  if (ci < NODE_COUNT_DEF && shadow_free[ci] != 0 &&
                      longint'(shadow_free[ci]) >= area) begin
                     if (c == 1 || c == 2) y += half;
                     if (c == 2 || c == 3) x += half;
                     node = ci;
                     side = half;
                     lvl++;
                     path[lvl] = node;
                     found = 1;
                  end
               end
               if (!found) break;
            end
            taken = shadow_free[node];
            // partly used or empty node is refused, never overlapped
            if (taken != 0 && taken == side * side) begin
               ok = 1;
               for (int i = 0; i < lvl; i++)
                  shadow_free[path[i]] = (shadow_free[path[i]] >= taken) ?
                                         shadow_free[path[i]] - taken : 0;
               shadow_free[node] = 0;
               if (x < box_lx) box_lx = x;
               if (y < box_ty) box_ty = y;
               if (x + side > box_rx) box_rx = x + side;
               if (y + side > box_by) box_by = y + side;
            end
         end
      end
      if (!ok) begin
         x = 0;
         y = 0;
         side = 0;
      end
      res = '{granted: ok, block_x: x[POS_W-1:0], block_y: y[POS_W-1:0],
              block_side: side[SIDE_W-1:0], bound_left: box_lx[POS_W-1:0],
              bound_top: box_ty[POS_W-1:0], bound_right: box_rx[SIDE_W-1:0],
              bound_bottom: box_by[SIDE_W-1:0]};
   endtask

   function automatic rsp_type mk_rsp(logic g, int x, int y, int s,
                                      int l, int t, int r, int b);
      return '{granted: g, block_x: POS_W'(x), block_y: POS_W'(y),
               block_side: SIDE_W'(s), bound_left: POS_W'(l), bound_top: POS_W'(t),
               bound_right: SIDE_W'(r), bound_bottom: SIDE_W'(b)};
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      n_err++;
      $display("mismatch on response %0d: %s got %0d want %0d", n_rsp, what, got, want);
   endtask

   function automatic int draw_gap();
      return quiet ? 0 : $urandom_range(0, 7);
   endfunction

   // offer one request; the prediction is made at the edge it is taken
   task automatic send_request(input logic mode, input logic [SIDE_W-1:0] side,
                               input bit typed, input rsp_type typed_rsp);
      int gap;
      rsp_type pred;
      gap = draw_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_mode         <= mode;
      req_request_side <= side;
      do @(posedge clock); while (req_stall);
      place_block(mode, side, pred);
      placement_q.push_back(typed ? typed_rsp : pred);
      n_req++;
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (placement_q.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_reg(input logic idx, input logic [SIDE_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == CSR_ROOT_SIDE) shadow_root = data;
      else shadow_min = data;
      rebuild_tree();
      n_cfg++;
   endtask

   // receiver: random hold-off per response, one long hold-off on request
   initial begin
      int gap;
      rsp_type got, want;
      @(negedge reset);
      forever begin
         gap = draw_gap();
         if (long_hold) begin
            long_hold = 1'b0;
            gap = LONG_HOLD;
         end
         if (gap > 0) begin
            rsp_stall <= 1'b1;
            repeat (gap) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
         got = '{granted: rsp_granted, block_x: rsp_block_x, block_y: rsp_block_y,
                 block_side: rsp_block_side, bound_left: rsp_bound_left,
                 bound_top: rsp_bound_top, bound_right: rsp_bound_right,
                 bound_bottom: rsp_bound_bottom};
         n_rsp++;
         if (placement_q.size() == 0) begin
            report_mismatch("responses outstanding", 0, 1);
         end else begin
            want = placement_q.pop_front();
            if (got.granted != want.granted)
               report_mismatch("granted", got.granted, want.granted);
            if (got.block_x != want.block_x)
               report_mismatch("block_x", got.block_x, want.block_x);
            if (got.block_y != want.block_y)
               report_mismatch("block_y", got.block_y, want.block_y);
            if (got.block_side != want.block_side)
               report_mismatch("block_side", got.block_side, want.block_side);
            if (got.bound_left != want.bound_left)
               report_mismatch("bound_left", got.bound_left, want.bound_left);
            if (got.bound_top != want.bound_top)
               report_mismatch("bound_top", got.bound_top, want.bound_top);
            if (got.bound_right != want.bound_right)
               report_mismatch("bound_right", got.bound_right, want.bound_right);
            if (got.bound_bottom != want.bound_bottom)
               report_mismatch("bound_bottom", got.bound_bottom, want.bound_bottom);
            if (want.granted) n_grant++;
         end
      end
   end

   // watchdog: too long without any handshake means the block hung
   initial begin
      int idle;
      idle = 0;
      while (idle < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
             (csr_valid && csr_ready))
            idle = 0;
         else
            idle++;
      end
      $display("watchdog expired, %0d responses outstanding", placement_q.size());
      $display("status: fail");
      $finish;
   end

   typedef struct {
      logic              mode;
      logic [SIDE_W-1:0] side;
      bit                typed;
      rsp_type           rsp;
   } directed_row;

   // configurations: defaults, depth limit, tiny atlas, oversized root with no
   // split, zero root, odd sizes, zero min side
   localparam int N_PHASES = 9;
   int phase_root [N_PHASES] = '{1024, 4096, 2, 8191, 0, 64, 4096, 3000, 1024};
   int phase_min  [N_PHASES] = '{32, 1, 1, 4096, 5, 8, 128, 100, 0};

   initial begin
      directed_row rows [$];
      rsp_type none, empty;
      int r, side, rt;
      rebuild_tree();
      none  = mk_rsp(0, 0, 0, 0, 1024 - 1024, 0, 1024, 1024);
      empty = mk_rsp(0, 0, 0, 0, BOX_MIN_INIT, BOX_MIN_INIT, 0, 0);
      // whole atlas, then full atlas refuses, then clear
      rows.push_back('{MODE_ALLOC, 13'd1024, 1, mk_rsp(1, 0, 0, 1024, 0, 0, 1024, 1024)});
      rows.push_back('{MODE_ALLOC, 13'd1, 1, none});
      rows.push_back('{MODE_CLEAR, 13'd0, 1, empty});
      // too large for the root
      rows.push_back('{MODE_ALLOC, 13'd8191, 1, empty});
      rows.push_back('{MODE_ALLOC, 13'd1025, 1, empty});
      rows.push_back('{MODE_ALLOC, 13'd4096, 1, empty});
      // zero request, smallest leaves, larger ones, partly used root
      rows.push_back('{MODE_ALLOC, 13'd0, 0, empty});
      rows.push_back('{MODE_ALLOC, 13'd1, 0, empty});
      rows.push_back('{MODE_ALLOC, 13'd32, 0, empty});
      rows.push_back('{MODE_ALLOC, 13'd33, 0, empty});
      rows.push_back('{MODE_ALLOC, 13'd512, 0, empty});
      rows.push_back('{MODE_ALLOC, 13'd513, 0, empty});
      rows.push_back('{MODE_ALLOC, 13'd1024, 0, empty});
      rows.push_back('{MODE_ALLOC, 13'd700, 0, empty});
      rows.push_back('{MODE_ALLOC, 13'd256, 0, empty});
      rows.push_back('{MODE_ALLOC, 13'd5461, 0, empty});
      rows.push_back('{MODE_CLEAR, 13'd8191, 1, empty});
      rows.push_back('{MODE_ALLOC, 13'd2730, 0, empty});
      rows.push_back('{MODE_ALLOC, 13'd600, 0, empty});
      rows.push_back('{MODE_ALLOC, 13'd128, 0, empty});

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed part at reset settings
      foreach (rows[i]) send_request(rows[i].mode, rows[i].side, rows[i].typed, rows[i].rsp);
      drain_results();

      for (int p = 0; p < N_PHASES; p++) begin
         write_reg(CSR_ROOT_SIDE, SIDE_W'(phase_root[p]));
         write_reg(CSR_MIN_SIDE, SIDE_W'(phase_min[p]));
         quiet = ($urandom_range(0, 3) == 0);
         rt = (phase_root[p] > SIDE_LIMIT) ? SIDE_LIMIT : phase_root[p];
         for (int n = 0; n < RAND_ITEMS; n++) begin
            // fill the block while the receiver holds off
            if (p == 1 && n == 20) begin
               long_hold = 1'b1;
               quiet = 1'b1;
            end
            if (p == 1 && n == 60) quiet = 1'b0;
            // sender pauses until nothing is outstanding
            if (p == 3 && n == 70) drain_results();
            r = $urandom_range(0, 99);
            if (r < 4) begin
               send_request(MODE_CLEAR, SIDE_W'($urandom_range(0, 8191)), 0, empty);
            end else begin
               if (r < 80)        // block-sized requests that mostly fit
                  side = (rt >> $urandom_range(0, 6)) + $urandom_range(0, 1) *
                         ($urandom_range(0, 2) - 1);
               else if (r < 90)
                  side = $urandom_range(0, 16);
               else
                  side = $urandom_range(0, 8191);
               if (side < 0) side = 0;
               send_request(MODE_ALLOC, SIDE_W'(side), 0, empty);
            end
         end
         drain_results();
      end

      $display("%0d requests, %0d responses, %0d grants, %0d register writes", n_req,
               n_rsp, n_grant, n_cfg);
      $display("covered %0d atlas settings incl. zero, tiny, oversized and depth limit",
               N_PHASES);
      if (n_err == 0) begin
         $display("status: pass");
      end else begin
         $display("%0d mismatches", n_err);
         $display("status: fail");
      end
      $finish;
   end
endmodule
`default_nettype wire

[sim.f]
hw/rtl/qtsba_pkg.sv
hw/rtl/qtsba_ram.sv
hw/rtl/quadtree_square_block_allocator.sv
hw/rtl/qtsba_checker.sv
test/tb_quadtree_square_block_allocator.sv
